[sv/bqse_pkg.sv]
// Shared types and constants for the bilinear quad shape evaluator.
package bqse_pkg;

	localparam int NODE_COUNT = 4;
	localparam int IN_W       = 296;
	localparam int OUT_W      = 200;
	localparam int USER_W     = 8;
	localparam int DET_W      = 64;
	localparam int NUM_W      = 68;
	localparam int QB         = 33;

	typedef logic signed [18:0] fac_t;
	typedef logic signed [31:0] q16_t;
	typedef logic [2:0] idx_t;

	localparam fac_t ONE_Q16 = 19'sd65536;

	localparam idx_t IDX_N0   = 3'd0;
	localparam idx_t IDX_N1   = 3'd1;
	localparam idx_t IDX_N2   = 3'd2;
	localparam idx_t IDX_N3   = 3'd3;
	localparam idx_t IDX_WXI  = 3'd4;
	localparam idx_t IDX_WETA = 3'd5;

	typedef struct packed {
		fac_t fam;
		fac_t fap;
		fac_t fbm;
		fac_t fbp;
		fac_t xi;
		fac_t eta;
		q16_t j00;
		q16_t j01;
		q16_t j10;
		q16_t j11;
		q16_t [NODE_COUNT-1:0] shp;
		q16_t wx;
		q16_t we;
		q16_t det16;
		q16_t px;
		q16_t py;
		logic bad;
		logic dzero;
		logic dneg;
		logic [DET_W-1:0] dmag;
	} item_t;

	typedef struct packed {
		idx_t idx;
		q16_t func;
		q16_t det16;
		q16_t px;
		q16_t py;
		logic bad;
		logic last;
		logic dzero;
	} side_t;

	typedef struct packed {
		side_t side;
		logic [DET_W-1:0] dmag;
		logic [1:0][NUM_W-1:0] num;
		logic [1:0] neg;
	} req_t;

	typedef struct packed {
		side_t side;
		q16_t dx;
		q16_t dy;
	} res_t;

endpackage

[sv/bqse_front.sv]
// Per-item pipeline: factors, Jacobian, shape values, global point and determinant.
module bqse_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [bqse_pkg::IN_W-1:0] in_data,
	output logic                    in_ready,
	output logic                    item_valid,
	output bqse_pkg::item_t         item,
	input  logic                    item_ready
);
	import bqse_pkg::*;

	typedef logic signed [32:0] dif_t;

	function automatic dif_t dif(input q16_t a, input q16_t b);
		return {a[31], a} - {b[31], b};
	endfunction

	function automatic q16_t sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		else if (v < -64'sd2147483648) return 32'sh80000000;
		else return v[31:0];
	endfunction

	function automatic q16_t clampj(input logic signed [35:0] v);
		if (v > 36'sd2147483647) return 32'sh7fffffff;
		else if (v < -36'sd2147483647) return 32'sh80000001;
		else return v[31:0];
	endfunction

	function automatic q16_t jround(input logic signed [51:0] a, input logic signed [51:0] b);
		logic signed [53:0] t;
		t = {{2{a[51]}}, a} + {{2{b[51]}}, b} + 54'sd131072;
		return clampj($signed(t[53:18]));
	endfunction

	function automatic q16_t shp_round(input logic signed [37:0] p);
		logic signed [38:0] t;
		t = {p[37], p} + 39'sd131072;
		return {{13{t[36]}}, t[36:18]};
	endfunction

	function automatic q16_t wil_round(input logic signed [35:0] s);
		logic signed [36:0] t;
		t = {s[35], s} - 37'sd4294967296 + 37'sd65536;
		return {{12{t[36]}}, t[36:17]};
	endfunction

	logic en1, en2, en3, en4, en5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	assign en5      = !v_s5 || item_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	q16_t x_in [NODE_COUNT];
	q16_t y_in [NODE_COUNT];
	logic signed [17:0] xi_in, eta_in;
	fac_t xi_e, eta_e;

	always_comb begin
		for (int i = 0; i < NODE_COUNT; i++) begin
			x_in[i] = in_data[64*i +: 32];
			y_in[i] = in_data[64*i+32 +: 32];
		end
	end
	assign xi_in  = in_data[256 +: 18];
	assign eta_in = in_data[274 +: 18];
	assign xi_e   = {xi_in[17], xi_in};
	assign eta_e  = {eta_in[17], eta_in};

	// stage 1: factors and edge differences
	fac_t fam_s1, fap_s1, fbm_s1, fbp_s1, xi_s1, eta_s1;
	dif_t dx10_s1, dx23_s1, dx30_s1, dx21_s1, dy10_s1, dy23_s1, dy30_s1, dy21_s1;
	q16_t x_s1 [NODE_COUNT];
	q16_t y_s1 [NODE_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			fam_s1  <= ONE_Q16 - xi_e;
			fap_s1  <= ONE_Q16 + xi_e;
			fbm_s1  <= ONE_Q16 - eta_e;
			fbp_s1  <= ONE_Q16 + eta_e;
			xi_s1   <= xi_e;
			eta_s1  <= eta_e;
			dx10_s1 <= dif(x_in[1], x_in[0]);
			dx23_s1 <= dif(x_in[2], x_in[3]);
			dx30_s1 <= dif(x_in[3], x_in[0]);
			dx21_s1 <= dif(x_in[2], x_in[1]);
			dy10_s1 <= dif(y_in[1], y_in[0]);
			dy23_s1 <= dif(y_in[2], y_in[3]);
			dy30_s1 <= dif(y_in[3], y_in[0]);
			dy21_s1 <= dif(y_in[2], y_in[1]);
			x_s1    <= x_in;
			y_s1    <= y_in;
		end
	end

	// stage 2: Jacobian partial products, shape products, squares
	logic signed [51:0] j00a_s2, j00b_s2, j01a_s2, j01b_s2;
	logic signed [51:0] j10a_s2, j10b_s2, j11a_s2, j11b_s2;
	logic signed [37:0] sp_s2 [NODE_COUNT];
	logic signed [35:0] sqx_s2, sqe_s2;
	fac_t fam_s2, fap_s2, fbm_s2, fbp_s2, xi_s2, eta_s2;
	q16_t x_s2 [NODE_COUNT];
	q16_t y_s2 [NODE_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			j00a_s2  <= fbm_s1 * dx10_s1;
			j00b_s2  <= fbp_s1 * dx23_s1;
			j10a_s2  <= fbm_s1 * dy10_s1;
			j10b_s2  <= fbp_s1 * dy23_s1;
			j01a_s2  <= fam_s1 * dx30_s1;
			j01b_s2  <= fap_s1 * dx21_s1;
			j11a_s2  <= fam_s1 * dy30_s1;
			j11b_s2  <= fap_s1 * dy21_s1;
			sp_s2[0] <= fam_s1 * fbm_s1;
			sp_s2[1] <= fap_s1 * fbm_s1;
			sp_s2[2] <= fap_s1 * fbp_s1;
			sp_s2[3] <= fam_s1 * fbp_s1;
			sqx_s2   <= xi_s1 * xi_s1;
			sqe_s2   <= eta_s1 * eta_s1;
			fam_s2   <= fam_s1;
			fap_s2   <= fap_s1;
			fbm_s2   <= fbm_s1;
			fbp_s2   <= fbp_s1;
			xi_s2    <= xi_s1;
			eta_s2   <= eta_s1;
			x_s2     <= x_s1;
			y_s2     <= y_s1;
		end
	end

	// stage 3: rounded Jacobian, shape values, Wilson values
	q16_t j00_s3, j01_s3, j10_s3, j11_s3, wx_s3, we_s3;
	q16_t shp_s3 [NODE_COUNT];
	fac_t fam_s3, fap_s3, fbm_s3, fbp_s3, xi_s3, eta_s3;
	q16_t x_s3 [NODE_COUNT];
	q16_t y_s3 [NODE_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			j00_s3 <= jround(j00a_s2, j00b_s2);
			j01_s3 <= jround(j01a_s2, j01b_s2);
			j10_s3 <= jround(j10a_s2, j10b_s2);
			j11_s3 <= jround(j11a_s2, j11b_s2);
			for (int i = 0; i < NODE_COUNT; i++) begin
				shp_s3[i] <= shp_round(sp_s2[i]);
			end
			wx_s3  <= wil_round(sqx_s2);
			we_s3  <= wil_round(sqe_s2);
			fam_s3 <= fam_s2;
			fap_s3 <= fap_s2;
			fbm_s3 <= fbm_s2;
			fbp_s3 <= fbp_s2;
			xi_s3  <= xi_s2;
			eta_s3 <= eta_s2;
			x_s3   <= x_s2;
			y_s3   <= y_s2;
		end
	end

	// stage 4: point products and determinant products
	logic signed [50:0] ppx_s4 [NODE_COUNT];
	logic signed [50:0] ppy_s4 [NODE_COUNT];
	logic signed [63:0] dpa_s4, dpb_s4;
	q16_t j00_s4, j01_s4, j10_s4, j11_s4, wx_s4, we_s4;
	q16_t shp_s4 [NODE_COUNT];
	fac_t fam_s4, fap_s4, fbm_s4, fbp_s4, xi_s4, eta_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			for (int i = 0; i < NODE_COUNT; i++) begin
				ppx_s4[i] <= shp_s3[i] * x_s3[i];
				ppy_s4[i] <= shp_s3[i] * y_s3[i];
			end
			dpa_s4 <= j00_s3 * j11_s3;
			dpb_s4 <= j01_s3 * j10_s3;
			j00_s4 <= j00_s3;
			j01_s4 <= j01_s3;
			j10_s4 <= j10_s3;
			j11_s4 <= j11_s3;
			wx_s4  <= wx_s3;
			we_s4  <= we_s3;
			shp_s4 <= shp_s3;
			fam_s4 <= fam_s3;
			fap_s4 <= fap_s3;
			fbm_s4 <= fbm_s3;
			fbp_s4 <= fbp_s3;
			xi_s4  <= xi_s3;
			eta_s4 <= eta_s3;
		end
	end

	// stage 5: point sums, determinant and its magnitude
	logic signed [52:0] pxt, pyt;
	logic signed [64:0] detf;
	logic signed [65:0] dett;
	logic [64:0] detn;
	item_t item_c;
	item_t item_s5;

	always_comb begin
		pxt = 53'sd32768;
		pyt = 53'sd32768;
		for (int i = 0; i < NODE_COUNT; i++) begin
			pxt = pxt + {{2{ppx_s4[i][50]}}, ppx_s4[i]};
			pyt = pyt + {{2{ppy_s4[i][50]}}, ppy_s4[i]};
		end
		detf = {dpa_s4[63], dpa_s4} - {dpb_s4[63], dpb_s4};
		dett = {detf[64], detf} + 66'sd32768;
		detn = -detf;
		item_c.fam   = fam_s4;
		item_c.fap   = fap_s4;
		item_c.fbm   = fbm_s4;
		item_c.fbp   = fbp_s4;
		item_c.xi    = xi_s4;
		item_c.eta   = eta_s4;
		item_c.j00   = j00_s4;
		item_c.j01   = j01_s4;
		item_c.j10   = j10_s4;
		item_c.j11   = j11_s4;
		for (int i = 0; i < NODE_COUNT; i++) begin
			item_c.shp[i] = shp_s4[i];
		end
		item_c.wx    = wx_s4;
		item_c.we    = we_s4;
		item_c.det16 = sat32({{14{dett[65]}}, dett[65:16]});
		item_c.px    = sat32({{27{pxt[52]}}, pxt[52:16]});
		item_c.py    = sat32({{27{pyt[52]}}, pyt[52:16]});
		item_c.bad   = detf[64] || (detf == '0);
		item_c.dzero = (detf == '0);
		item_c.dneg  = detf[64];
		item_c.dmag  = detf[64] ? detn[DET_W-1:0] : detf[DET_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			item_s5 <= item_c;
		end
	end

	assign item_valid = v_s5;
	assign item       = item_s5;

endmodule

[sv/bqse_entry.sv]
// Result sequencer: holds one item, issues six entries and forms their numerators.
module bqse_entry (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  bqse_pkg::item_t item,
	output logic            item_ready,
	output logic            req_valid,
	output bqse_pkg::req_t  req,
	input  logic            req_ready
);
	import bqse_pkg::*;

	item_t hold_q;
	logic  hv_q;
	idx_t  cnt_q;
	logic  e1_en, e2_en, issue, last_issue;
	logic  v_s1, v_s2;

	assign e2_en      = !v_s2 || req_ready;
	assign e1_en      = !v_s1 || e2_en;
	assign issue      = hv_q && e1_en;
	assign last_issue = issue && (cnt_q == IDX_WETA);
	assign item_ready = !hv_q || last_issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q  <= 1'b0;
			cnt_q <= IDX_N0;
		end else if (item_valid && item_ready) begin
			hv_q  <= 1'b1;
			cnt_q <= IDX_N0;
		end else if (issue) begin
			cnt_q <= cnt_q + 3'd1;
			if (last_issue) begin
				hv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			hold_q <= item;
		end
	end

	// p pairs with the xi derivative, q with the eta derivative
	fac_t  p_c, q_c;
	q16_t  func_c;
	logic  wil_c;
	side_t side_c;

	always_comb begin
		p_c    = '0;
		q_c    = '0;
		func_c = '0;
		wil_c  = 1'b0;
		case (cnt_q)
			IDX_N0: begin
				p_c    = -hold_q.fbm;
				q_c    = -hold_q.fam;
				func_c = hold_q.shp[0];
			end
			IDX_N1: begin
				p_c    = hold_q.fbm;
				q_c    = -hold_q.fap;
				func_c = hold_q.shp[1];
			end
			IDX_N2: begin
				p_c    = hold_q.fbp;
				q_c    = hold_q.fap;
				func_c = hold_q.shp[2];
			end
			IDX_N3: begin
				p_c    = -hold_q.fbp;
				q_c    = hold_q.fam;
				func_c = hold_q.shp[3];
			end
			IDX_WXI: begin
				p_c    = hold_q.xi;
				func_c = hold_q.wx;
				wil_c  = 1'b1;
			end
			IDX_WETA: begin
				q_c    = hold_q.eta;
				func_c = hold_q.we;
				wil_c  = 1'b1;
			end
			default: begin
				p_c = '0;
			end
		endcase
		side_c.idx   = cnt_q;
		side_c.func  = func_c;
		side_c.det16 = hold_q.det16;
		side_c.px    = hold_q.px;
		side_c.py    = hold_q.py;
		side_c.bad   = hold_q.bad;
		side_c.last  = (cnt_q == IDX_WETA);
		side_c.dzero = hold_q.dzero;
	end

	// stage 1: adjugate products
	logic signed [50:0] pj11_s1, qj10_s1, qj00_s1, pj01_s1;
	side_t side_s1;
	logic  wil_s1, dneg_s1;
	logic [DET_W-1:0] dmag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (e1_en) begin
			v_s1 <= hv_q;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pj11_s1 <= $signed(p_c) * $signed(hold_q.j11);
			qj10_s1 <= $signed(q_c) * $signed(hold_q.j10);
			qj00_s1 <= $signed(q_c) * $signed(hold_q.j00);
			pj01_s1 <= $signed(p_c) * $signed(hold_q.j01);
			side_s1 <= side_c;
			wil_s1  <= wil_c;
			dneg_s1 <= hold_q.dneg;
			dmag_s1 <= hold_q.dmag;
		end
	end

	// stage 2: numerators as sign and scaled magnitude
	logic signed [51:0] nx, ny, nxn, nyn;
	logic [51:0] nxm, nym;
	req_t req_c;
	req_t req_s2;

	always_comb begin
		nx  = {pj11_s1[50], pj11_s1} - {qj10_s1[50], qj10_s1};
		ny  = {qj00_s1[50], qj00_s1} - {pj01_s1[50], pj01_s1};
		nxn = -nx;
		nyn = -ny;
		nxm = nx[51] ? nxn : nx;
		nym = ny[51] ? nyn : ny;
		req_c.side   = side_s1;
		req_c.dmag   = dmag_s1;
		req_c.neg[0] = nx[51] ^ dneg_s1;
		req_c.neg[1] = ny[51] ^ dneg_s1;
		if (wil_s1) begin
			req_c.num[0] = {16'd0, nxm} << 17;
			req_c.num[1] = {16'd0, nym} << 17;
		end else begin
			req_c.num[0] = {16'd0, nxm} << 15;
			req_c.num[1] = {16'd0, nym} << 15;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (e2_en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (e2_en && v_s1) begin
			req_s2 <= req_c;
		end
	end

	assign req_valid = v_s2;
	assign req       = req_s2;

endmodule

[sv/bqse_div.sv]
// Pipelined restoring divider, two lanes, one quotient bit per stage, with final rounding.
module bqse_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  bqse_pkg::req_t req,
	output logic           req_ready,
	output logic           res_valid,
	output bqse_pkg::res_t res,
	input  logic           res_ready
);
	import bqse_pkg::*;

	localparam int HI_W = NUM_W - QB;

	typedef struct packed {
		logic [DET_W:0]  r;
		logic [QB-1:0]   q;
		logic [QB-1:0]   low;
		logic            neg;
		logic            over;
	} lane_t;

	typedef struct packed {
		side_t           side;
		logic [DET_W-1:0] d;
		lane_t [1:0]     ln;
	} dstage_t;

	function automatic q16_t finish(input lane_t l, input logic dzero);
		logic [QB:0] t;
		logic [QB-1:0] m;
		t = {1'b0, l.q} + {{QB{1'b0}}, 1'b1};
		m = t[QB:1];
		if (dzero) return '0;
		else if (l.neg) begin
			if (l.over || m[32] || (m[31] && (m[30:0] != '0))) return 32'sh80000000;
			else return -m[31:0];
		end else begin
			if (l.over || m[32] || m[31]) return 32'sh7fffffff;
			else return m[31:0];
		end
	endfunction

	dstage_t st_s [QB+1];
	logic    v_s  [QB+1];
	logic    en   [QB+2];
	logic    out_v_q;
	res_t    res_q;

	assign en[QB+1]  = !out_v_q || res_ready;
	assign req_ready = en[0];

	for (genvar k = 0; k <= QB; k++) begin : g_en
		assign en[k] = !v_s[k] || en[k+1];
	end

	// stage 0: range check, first partial remainder
	dstage_t st0_c;
	logic [HI_W-1:0] hi [2];

	always_comb begin
		st0_c.side = req.side;
		st0_c.d    = req.dmag;
		for (int l = 0; l < 2; l++) begin
			hi[l]             = req.num[l][NUM_W-1:QB];
			st0_c.ln[l].over  = {{(DET_W-HI_W){1'b0}}, hi[l]} >= req.dmag;
			st0_c.ln[l].r     = st0_c.ln[l].over ? '0 : {{(DET_W+1-HI_W){1'b0}}, hi[l]};
			st0_c.ln[l].q     = '0;
			st0_c.ln[l].low   = req.num[l][QB-1:0];
			st0_c.ln[l].neg   = req.neg[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en[0]) begin
			v_s[0] <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0] && req_valid) begin
			st_s[0] <= st0_c;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_step
		dstage_t        nx_c;
		logic [DET_W:0] rr [2];

		always_comb begin
			nx_c = st_s[k-1];
			for (int l = 0; l < 2; l++) begin
				rr[l] = {st_s[k-1].ln[l].r[DET_W-1:0], st_s[k-1].ln[l].low[QB-k]};
				if (rr[l] >= {1'b0, st_s[k-1].d}) begin
					nx_c.ln[l].r = rr[l] - {1'b0, st_s[k-1].d};
					nx_c.ln[l].q = {st_s[k-1].ln[l].q[QB-2:0], 1'b1};
				end else begin
					nx_c.ln[l].r = rr[l];
					nx_c.ln[l].q = {st_s[k-1].ln[l].q[QB-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k] && v_s[k-1]) begin
				st_s[k] <= nx_c;
			end
		end
	end

	// output register: round half away from zero, saturate, apply sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en[QB+1]) begin
			out_v_q <= v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en[QB+1] && v_s[QB]) begin
			res_q.side <= st_s[QB].side;
			res_q.dx   <= finish(st_s[QB].ln[0], st_s[QB].side.dzero);
			res_q.dy   <= finish(st_s[QB].ln[1], st_s[QB].side.dzero);
		end
	end

	assign res_valid = out_v_q;
	assign res       = res_q;

endmodule

[sv/bilinear_quad_shape_eval_top.sv]
// Top level of the bilinear quad shape evaluator with Wilson modes.
//
//  channel   dir  signals                        per transfer
//  s_axis    in   tvalid tready tdata[295:0]     one element and point
//  m_axis    out  tvalid tready tdata tuser tlast one shape entry, six per element
//
// An element is taken in one transfer; its six entries leave one after another
// through the single result channel, so the sustained rate is set by the entry
// counter, which takes the next element as the last entry of the held one issues.
// On the way from input transfer to the first entry transfer an element passes
// 5 element stages, the entry hold register, 2 numerator stages, 35 divider stages.
// Reset clears valid bits and the entry counter only. Each stage stalls on its
// own; bubbles close up and no transfer is lost or repeated.
module bilinear_quad_shape_eval_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// node_x0, node_y0, node_x1, node_y1, node_x2, node_y2, node_x3, node_y3,
	// point_xi, point_eta, zero pad
	input  logic [bqse_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// func_value, deriv_x, deriv_y, jacobian_det, point_x, point_y, bad_jacobian,
	// zero pad
	output logic [bqse_pkg::OUT_W-1:0]  m_axis_tdata,
	// entry_index, zero pad
	output logic [bqse_pkg::USER_W-1:0] m_axis_tuser,
	output logic                        m_axis_tlast
);
	import bqse_pkg::*;

	logic  item_valid, item_ready, req_valid, req_ready;
	item_t item;
	req_t  req;
	res_t  res;

	bqse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_data    (s_axis_tdata),
		.in_ready   (s_axis_tready),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready)
	);

	bqse_entry u_entry (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready),
		.req_valid  (req_valid),
		.req        (req),
		.req_ready  (req_ready)
	);

	bqse_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.res_valid (m_axis_tvalid),
		.res       (res),
		.res_ready (m_axis_tready)
	);

	assign m_axis_tdata = {7'd0, res.side.bad, res.side.py, res.side.px, res.side.det16,
		res.dy, res.dx, res.side.func};
	assign m_axis_tuser = {5'd0, res.side.idx};
	assign m_axis_tlast = res.side.last;

endmodule
